FILE: sv/rrtq_pkg.sv
// ---------------------------------------------------------------------------
// rrtq_pkg
// Shared types and constants of the round-robin thread queue: operation and
// result codes, the command that steers the row of queue cells, FSM states.
// ---------------------------------------------------------------------------
package rrtq_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int PID_BITS_DEF    = 8;

    // Fixed widths of the word fields.
    localparam int OP_W    = 3;
    localparam int PID_W   = 8;
    localparam int RC_W    = 3;
    localparam int LEFT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_EXIT     = 3'd2,
        OP_KILL     = 3'd3,
        OP_REAP     = 3'd4,
        OP_TICK     = 3'd5
    } t_op;

    typedef enum logic [RC_W-1:0] {
        RC_OK         = 3'd0,
        RC_EMPTY      = 3'd1,
        RC_CLEARED    = 3'd2,
        RC_FULL       = 3'd3,
        RC_NONE_READY = 3'd4
    } t_rc;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT,
        CMD_CREATE,
        CMD_KILL,
        CMD_HEAD_DEAD
    } t_cell_cmd;

    // Broadcast control to every cell of the row.
    typedef struct packed {
        t_cell_cmd        cmd;
        logic             insert;   // on a shift, load the tail cell from the insert bus
        logic [PID_W-1:0] target;   // pid to match on a kill
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REAP,
        ST_SCHED,
        ST_ROT
    } t_state;

endpackage

FILE: sv/rrtq_cell.sv
// ---------------------------------------------------------------------------
// rrtq_cell
// One queue position: holds a pid and a dead mark, shifts toward the head,
// loads from the insert bus at the tail and matches pids on a kill.
// ---------------------------------------------------------------------------
module rrtq_cell #(
    parameter int MAX_THREADS = rrtq_pkg::MAX_THREADS_DEF,
    parameter int PID_BITS    = rrtq_pkg::PID_BITS_DEF,
    parameter int IDX         = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrtq_pkg::t_cell_ctl            i_ctl,
    input  logic [$clog2(MAX_THREADS)-1:0] i_tail_idx,
    input  logic [PID_BITS-1:0]            i_ins_pid,
    input  logic                           i_ins_dead,
    input  logic [PID_BITS-1:0]            i_nb_pid,
    input  logic                           i_nb_dead,
    output logic [PID_BITS-1:0]            o_pid,
    output logic                           o_dead
);

    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CMP_W = (PID_BITS > rrtq_pkg::PID_W) ? PID_BITS : rrtq_pkg::PID_W;

    logic [PID_BITS-1:0] r_pid, n_pid;
    logic                r_dead, n_dead;
    logic                w_hit;
    logic                w_match;

    assign w_hit   = (i_tail_idx == IDX_W'(IDX));
    assign w_match = (CMP_W'(r_pid) == CMP_W'(i_ctl.target));

    always_comb begin
        n_pid  = r_pid;
        n_dead = r_dead;
        case (i_ctl.cmd)
            rrtq_pkg::CMD_SHIFT: begin
                if (i_ctl.insert && w_hit) begin
                    n_pid  = i_ins_pid;
                    n_dead = i_ins_dead;
                end else begin
                    n_pid  = i_nb_pid;
                    n_dead = i_nb_dead;
                end
            end
            rrtq_pkg::CMD_CREATE: begin
                if (w_hit) begin
                    n_pid  = i_ins_pid;
                    n_dead = 1'b0;
                end
            end
            rrtq_pkg::CMD_KILL: begin
                if (w_match) begin
                    n_dead = 1'b1;
                end
            end
            rrtq_pkg::CMD_HEAD_DEAD: begin
                if (IDX == 0) begin
                    n_dead = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead <= 1'b0;
        end else begin
            r_dead <= n_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid <= n_pid;
    end

    assign o_pid  = r_pid;
    assign o_dead = r_dead;

endmodule

FILE: sv/round_robin_thread_queue.sv
// ---------------------------------------------------------------------------
// round_robin_thread_queue
// Round-robin run queue kept as a row of cells, cell 0 being the head.
// ---------------------------------------------------------------------------
// Create, kill, empty reap and unused codes strobe in the cycle after
// accept; schedule/exit run the schedule state, then r rotations (r <=
// entries); reap does one step per entry; tick does reap, then schedule.
// Each rotation and reap step is one shift of the cell row per cycle.
// busy is low in the strobe cycle, so the next word may start there.
// Reset (sync, active low) empties the queue and zeroes the pid counter.
module round_robin_thread_queue #(
    parameter int MAX_THREADS = rrtq_pkg::MAX_THREADS_DEF,
    parameter int PID_BITS    = rrtq_pkg::PID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rrtq_pkg::OP_W-1:0]   i_operation,
    input  logic [rrtq_pkg::PID_W-1:0]  i_target_pid,
    output logic                        o_strobe,
    output logic [rrtq_pkg::RC_W-1:0]   o_result_code,
    output logic [rrtq_pkg::PID_W-1:0]  o_pid_out,
    output logic [rrtq_pkg::LEFT_W-1:0] o_entries_left
);

    localparam int IDX_W   = $clog2(MAX_THREADS);
    localparam int CNT_W   = $clog2(MAX_THREADS + 1);
    localparam int PEXT_W  = (PID_BITS > rrtq_pkg::PID_W) ? PID_BITS : rrtq_pkg::PID_W;
    localparam int CEXT_W  = (CNT_W > rrtq_pkg::LEFT_W) ? CNT_W : rrtq_pkg::LEFT_W;

    // Trim or widen a queue pid to the word's pid field.
    function automatic logic [rrtq_pkg::PID_W-1:0] pid_to_word(input logic [PID_BITS-1:0] p);
        logic [PEXT_W-1:0] ext;
        ext = PEXT_W'(p);
        return ext[rrtq_pkg::PID_W-1:0];
    endfunction

    // Cell row.
    logic [PID_BITS-1:0] w_pid  [MAX_THREADS];
    logic                w_dead [MAX_THREADS];

    rrtq_pkg::t_cell_ctl w_ctl;
    logic [IDX_W-1:0]    w_tail_idx;
    logic [PID_BITS-1:0] w_ins_pid;
    logic                w_ins_dead;

    // Control state.
    rrtq_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PID_BITS-1:0] r_next_pid, n_next_pid;
    logic [CNT_W-1:0]    r_left, n_left;          // steps still to go in a pass
    logic                r_first, n_first;        // first reap step keeps the head
    logic                r_then_sched, n_then_sched;

    // Result word.
    logic                         r_strobe, n_strobe;
    rrtq_pkg::t_rc                r_code, n_code;
    logic [rrtq_pkg::PID_W-1:0]   r_pid_out, n_pid_out;

    logic [CNT_W-1:0]  w_count_m1;
    logic [CEXT_W-1:0] w_count_ext;
    logic              w_drop;

    assign w_count_m1  = r_count - CNT_W'(1);
    assign w_count_ext = CEXT_W'(r_count);
    assign w_drop      = w_dead[0] && !r_first;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_THREADS; gi++) begin : g_cell
            // The last cell's neighbor is never taken into a live entry.
            localparam int NB = (gi + 1 < MAX_THREADS) ? gi + 1 : 0;
            rrtq_cell #(
                .MAX_THREADS (MAX_THREADS),
                .PID_BITS    (PID_BITS),
                .IDX         (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_tail_idx (w_tail_idx),
                .i_ins_pid  (w_ins_pid),
                .i_ins_dead (w_ins_dead),
                .i_nb_pid   (w_pid[NB]),
                .i_nb_dead  (w_dead[NB]),
                .o_pid      (w_pid[gi]),
                .o_dead     (w_dead[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_next_pid   = r_next_pid;
        n_left       = r_left;
        n_first      = r_first;
        n_then_sched = r_then_sched;
        n_strobe     = 1'b0;
        n_code       = r_code;
        n_pid_out    = r_pid_out;

        w_ctl.cmd    = rrtq_pkg::CMD_HOLD;
        w_ctl.insert = 1'b0;
        w_ctl.target = i_target_pid;
        // Tail is the last live cell for a shift; create overrides it.
        w_tail_idx   = w_count_m1[IDX_W-1:0];
        w_ins_pid    = w_pid[0];
        w_ins_dead   = w_dead[0];

        case (r_state)
            rrtq_pkg::ST_IDLE: begin
                if (start) begin
                    case (rrtq_pkg::t_op'(i_operation))
                        rrtq_pkg::OP_CREATE: begin
                            n_strobe  = 1'b1;
                            if (r_count == CNT_W'(MAX_THREADS)) begin
                                n_code    = rrtq_pkg::RC_FULL;
                                n_pid_out = '0;
                            end else begin
                                // Append at the first free cell.
                                w_ctl.cmd  = rrtq_pkg::CMD_CREATE;
                                w_tail_idx = r_count[IDX_W-1:0];
                                w_ins_pid  = r_next_pid;
                                n_code     = rrtq_pkg::RC_OK;
                                n_pid_out  = pid_to_word(r_next_pid);
                                n_next_pid = r_next_pid + PID_BITS'(1);
                                n_count    = r_count + CNT_W'(1);
                            end
                        end
                        rrtq_pkg::OP_SCHEDULE: begin
                            n_state = rrtq_pkg::ST_SCHED;
                        end
                        rrtq_pkg::OP_EXIT: begin
                            if (r_count != '0) begin
                                w_ctl.cmd = rrtq_pkg::CMD_HEAD_DEAD;
                            end
                            n_state = rrtq_pkg::ST_SCHED;
                        end
                        rrtq_pkg::OP_KILL: begin
                            n_strobe  = 1'b1;
                            n_pid_out = '0;
                            if (r_count == '0) begin
                                n_code = rrtq_pkg::RC_EMPTY;
                            end else begin
                                // Cells beyond the count are rewritten on create.
                                w_ctl.cmd = rrtq_pkg::CMD_KILL;
                                n_code    = rrtq_pkg::RC_OK;
                            end
                        end
                        rrtq_pkg::OP_REAP, rrtq_pkg::OP_TICK: begin
                            n_then_sched = (rrtq_pkg::t_op'(i_operation) == rrtq_pkg::OP_TICK);
                            if (r_count == '0) begin
                                if (n_then_sched) begin
                                    n_state = rrtq_pkg::ST_SCHED;
                                end else begin
                                    n_strobe  = 1'b1;
                                    n_code    = rrtq_pkg::RC_EMPTY;
                                    n_pid_out = '0;
                                end
                            end else begin
                                n_left  = r_count;
                                n_first = 1'b1;
                                n_state = rrtq_pkg::ST_REAP;
                            end
                        end
                        default: begin
                            n_strobe  = 1'b1;
                            n_code    = rrtq_pkg::RC_OK;
                            n_pid_out = '0;
                        end
                    endcase
                end
            end

            rrtq_pkg::ST_REAP: begin
                // Pop the head; requeue it at the tail unless it is dead and not the first step.
                w_ctl.cmd    = rrtq_pkg::CMD_SHIFT;
                w_ctl.insert = !w_drop;
                if (w_drop) begin
                    n_count = w_count_m1;
                end
                n_first = 1'b0;
                n_left  = r_left - CNT_W'(1);
                if (r_left == CNT_W'(1)) begin
                    if (r_then_sched) begin
                        n_state = rrtq_pkg::ST_SCHED;
                    end else begin
                        n_state   = rrtq_pkg::ST_IDLE;
                        n_strobe  = 1'b1;
                        n_code    = rrtq_pkg::RC_OK;
                        n_pid_out = '0;
                    end
                end
            end

            rrtq_pkg::ST_SCHED: begin
                n_pid_out = '0;
                if (r_count == '0) begin
                    n_state  = rrtq_pkg::ST_IDLE;
                    n_strobe = 1'b1;
                    n_code   = rrtq_pkg::RC_EMPTY;
                end else if (r_count == CNT_W'(1)) begin
                    // A single thread left: empty the queue, restart pids.
                    n_state    = rrtq_pkg::ST_IDLE;
                    n_strobe   = 1'b1;
                    n_code     = rrtq_pkg::RC_CLEARED;
                    n_count    = '0;
                    n_next_pid = '0;
                end else begin
                    n_left  = r_count;
                    n_state = rrtq_pkg::ST_ROT;
                end
            end

            rrtq_pkg::ST_ROT: begin
                // Rotate by one; cell 1 becomes the head.
                w_ctl.cmd    = rrtq_pkg::CMD_SHIFT;
                w_ctl.insert = 1'b1;
                n_left       = r_left - CNT_W'(1);
                if (!w_dead[1]) begin
                    n_state   = rrtq_pkg::ST_IDLE;
                    n_strobe  = 1'b1;
                    n_code    = rrtq_pkg::RC_OK;
                    n_pid_out = pid_to_word(w_pid[1]);
                end else if (r_left == CNT_W'(1)) begin
                    // Full turn done, order is back where it began.
                    n_state   = rrtq_pkg::ST_IDLE;
                    n_strobe  = 1'b1;
                    n_code    = rrtq_pkg::RC_NONE_READY;
                    n_pid_out = '0;
                end
            end

            default: begin
                n_state = rrtq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rrtq_pkg::ST_IDLE;
            r_count      <= '0;
            r_next_pid   <= '0;
            r_left       <= '0;
            r_first      <= 1'b0;
            r_then_sched <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_next_pid   <= n_next_pid;
            r_left       <= n_left;
            r_first      <= n_first;
            r_then_sched <= n_then_sched;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_pid_out <= n_pid_out;
    end

    // The count register already holds the post-operation value in the strobe cycle.
    assign busy           = (r_state != rrtq_pkg::ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_result_code  = r_code;
    assign o_pid_out      = r_pid_out;
    assign o_entries_left = w_count_ext[rrtq_pkg::LEFT_W-1:0];

endmodule

FILE: sv/rrtq_checker.sv
// ---------------------------------------------------------------------------
// rrtq_checker
// Port-level checks of the round-robin thread queue, bound to the top level.
// ---------------------------------------------------------------------------
module rrtq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [rrtq_pkg::OP_W-1:0]   i_operation,
    input logic                        o_strobe,
    input logic [rrtq_pkg::RC_W-1:0]   o_result_code,
    input logic [rrtq_pkg::PID_W-1:0]  o_pid_out,
    input logic [rrtq_pkg::LEFT_W-1:0] o_entries_left
);

    // Create strobes in the cycle after it is taken, full or not.
    a_create_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == rrtq_pkg::OP_CREATE) |=> (o_strobe && !busy))
        else $error("create word did not strobe on the next cycle");

    // An operation that raises busy holds it until its strobe.
    a_busy_until_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy)) |-> o_strobe)
        else $error("busy dropped without a result strobe");

    // Only an ok result carries a pid.
    a_pid_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_code != rrtq_pkg::RC_OK) |-> (o_pid_out == '0))
        else $error("non-ok result with nonzero pid");

    // A cleared or empty result reports no entries.
    a_cleared_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result_code == rrtq_pkg::RC_CLEARED
                      || o_result_code == rrtq_pkg::RC_EMPTY)) |-> (o_entries_left == '0))
        else $error("empty or cleared result with entries left");

endmodule

bind round_robin_thread_queue rrtq_checker u_rrtq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_strobe       (o_strobe),
    .o_result_code  (o_result_code),
    .o_pid_out      (o_pid_out),
    .o_entries_left (o_entries_left)
);
